/* sv/slrbm_pkg.sv */
// ----------------------------------------------------------------------------
// slrbm_pkg
// Shared types and constants for the serial-loaded ROM bank mapper.
// ----------------------------------------------------------------------------
package slrbm_pkg;

   // request op codes
   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_PRG_READ = 2'd1;
   localparam logic [1:0] OP_CHR_READ = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_PRG_BANK_COUNT = 2'd0;
   localparam logic [1:0] REG_PRG_BANK_MASK  = 2'd1;
   localparam logic [1:0] REG_CHR_BANK_MASK  = 2'd2;
   localparam logic [1:0] REG_CHR_IS_RAM     = 2'd3;

   localparam int CSR_ADDR_W = 4;

   // write regions, address bits 15..13
   localparam logic [2:0] RGN_CONTROL  = 3'b100;
   localparam logic [2:0] RGN_CHR_LOW  = 3'b101;
   localparam logic [2:0] RGN_CHR_HIGH = 3'b110;
   localparam logic [2:0] RGN_PRG      = 3'b111;

   localparam logic [5:0] SHIFT_MARK = 6'b100000;

   typedef struct packed {
      logic [5:0] prg_bank_count;
      logic [4:0] prg_bank_mask;
      logic [4:0] chr_bank_mask;
      logic       chr_is_ram;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  value;
      logic [31:0] cycle_stamp;
   } req_type;

endpackage

/* sv/slrbm_if.sv */
// ----------------------------------------------------------------------------
// slrbm request / response channels
// Valid/ready channels carrying one mapper request and one response.
// ----------------------------------------------------------------------------
interface slrbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] address;
   logic [7:0]  value;
   logic [31:0] cycle_stamp;

   modport source (output valid, op, address, value, cycle_stamp, input ready);
   modport sink   (input valid, op, address, value, cycle_stamp, output ready);
endinterface

interface slrbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [18:0] rom_offset;
   logic [1:0]  mirroring;

   modport source (output valid, rom_offset, mirroring, input ready);
   modport sink   (input valid, rom_offset, mirroring, output ready);
endinterface

/* sv/serial_loaded_rom_bank_mapper_top.sv */
// ----------------------------------------------------------------------------
// serial_loaded_rom_bank_mapper_top
// Cartridge bank mapper: serial register load and ROM offset translation.
// ----------------------------------------------------------------------------
// One request per clock: a request is captured in the input register, and the
// mapper state and the translated offset computed from it land in the
// response register once that register can take them. Every request gives
// exactly one response. The input register takes a new request whenever it is
// empty or its own request moves on into the response register, so a waiting
// response holds off the sender only once both registers are full. The rate
// is set by the single pass through the translation logic; state written by a
// mapper write is seen by the very next request. The user must configure via
// the APB-style port (4 registers at byte addresses 0, 4, 8, 12) only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_loaded_rom_bank_mapper_top
   import slrbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   slrbm_req_if.sink             req_ch,
   slrbm_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type     cfg;

   // input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;

   // response register
   logic        out_valid_ff, out_valid_in;
   logic [18:0] out_offset_ff;
   logic [1:0]  out_mirror_ff;

   logic        advance;   // response register can take a new result
   logic        req_fire;
   logic        commit;    // request in the input register retires
   logic [18:0] core_offset;
   logic [1:0]  core_mirror;

   slrbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign commit       = in_valid_ff && advance;

   // hold the request until its result moves into the response register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   slrbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .commit     (commit),
      .item       (in_data_ff),
      .rom_offset (core_offset),
      .mirroring  (core_mirror)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.op          <= req_ch.op;
         in_data_ff.address     <= req_ch.address;
         in_data_ff.value       <= req_ch.value;
         in_data_ff.cycle_stamp <= req_ch.cycle_stamp;
      end
      if (commit) begin
         out_offset_ff <= core_offset;
         out_mirror_ff <= core_mirror;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.rom_offset = out_offset_ff;
   assign rsp_ch.mirroring  = out_mirror_ff;

endmodule

/* sv/slrbm_csr.sv */
// ----------------------------------------------------------------------------
// slrbm_csr
// APB-style configuration registers of the bank mapper.
// ----------------------------------------------------------------------------
module slrbm_csr
   import slrbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PRG_BANK_COUNT: cfg_in.prg_bank_count = pwdata[5:0];
            REG_PRG_BANK_MASK:  cfg_in.prg_bank_mask  = pwdata[4:0];
            REG_CHR_BANK_MASK:  cfg_in.chr_bank_mask  = pwdata[4:0];
            REG_CHR_IS_RAM:     cfg_in.chr_is_ram     = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PRG_BANK_COUNT: prdata = {26'd0, cfg_ff.prg_bank_count};
         REG_PRG_BANK_MASK:  prdata = {27'd0, cfg_ff.prg_bank_mask};
         REG_CHR_BANK_MASK:  prdata = {27'd0, cfg_ff.chr_bank_mask};
         REG_CHR_IS_RAM:     prdata = {31'd0, cfg_ff.chr_is_ram};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_bank_count <= 6'd2;
         cfg_ff.prg_bank_mask  <= 5'd1;
         cfg_ff.chr_bank_mask  <= 5'd1;
         cfg_ff.chr_is_ram     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/slrbm_core.sv */
// ----------------------------------------------------------------------------
// slrbm_core
// Serial load register, bank state and address translation.
// ----------------------------------------------------------------------------
module slrbm_core
   import slrbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        commit,
   input  req_type     item,
   output logic [18:0] rom_offset,
   output logic [1:0]  mirroring
);

   typedef struct packed {
      logic [4:0] low;
      logic [4:0] high;
      logic       is_last;
   } prg_map_type;

   logic [5:0]  shift_ff, shift_in;
   logic [31:0] last_cycle_ff, last_cycle_in;
   logic        last_valid_ff, last_valid_in;
   logic [1:0]  prg_win_ff, prg_win_in;
   logic        chr_mode_ff, chr_mode_in;
   logic [4:0]  prg_sel_ff, prg_sel_in;
   logic [4:0]  chr_sel_lo_ff, chr_sel_lo_in;
   logic [4:0]  chr_sel_hi_ff, chr_sel_hi_in;
   logic [1:0]  mirror_ff, mirror_in;
   prg_map_type prg_map_ff, prg_map_in;

   logic        stamp_repeat;
   logic [5:0]  shifted;
   logic [4:0]  data;
   logic        prg_touch;
   logic [4:0]  chr_lo_bank, chr_hi_bank;
   logic [4:0]  prg_bank;
   logic [4:0]  last_bank;

   // bank windows after a program mode or select change
   function automatic prg_map_type prg_remap(input logic [1:0] mode, input logic [4:0] sel,
                                             input logic [5:0] count,
                                             input prg_map_type cur);
      prg_map_type m;
      m = cur;
      case (mode)
         2'd0, 2'd1: begin
            m.low     = {sel[4:1], 1'b0};
            m.high    = {sel[4:1], 1'b1};
            m.is_last = 1'b0;
         end
         2'd2: begin
            m.low     = {sel[4], 4'd0};
            m.high    = sel;
            m.is_last = 1'b0;
         end
         default: begin
            m.low = sel;
            if (count > 6'd16) begin
               m.high    = sel[4] ? 5'd31 : 5'd15;
               m.is_last = 1'b0;
            end else begin
               m.is_last = 1'b1;
            end
         end
      endcase
      return m;
   endfunction

   assign stamp_repeat = last_valid_ff && (item.cycle_stamp == last_cycle_ff);
   assign shifted      = {item.value[0], shift_ff[5:1]};
   assign data         = shifted[5:1];

   always_comb begin
      shift_in      = shift_ff;
      last_cycle_in = last_cycle_ff;
      last_valid_in = last_valid_ff;
      prg_win_in    = prg_win_ff;
      chr_mode_in   = chr_mode_ff;
      prg_sel_in    = prg_sel_ff;
      chr_sel_lo_in = chr_sel_lo_ff;
      chr_sel_hi_in = chr_sel_hi_ff;
      mirror_in     = mirror_ff;
      prg_touch     = 1'b0;
      if (item.op == OP_WRITE) begin
         last_cycle_in = item.cycle_stamp;
         last_valid_in = 1'b1;
         if (item.value[7]) begin
            shift_in   = SHIFT_MARK;
            prg_win_in = 2'd3;
            prg_touch  = 1'b1;
         end else if (!stamp_repeat) begin
            shift_in = shifted;
            if (shifted[0]) begin
               shift_in = SHIFT_MARK;
               case (item.address[15:13])
                  RGN_CONTROL: begin
                     mirror_in   = data[1:0];
                     chr_mode_in = data[4];
                     prg_win_in  = data[3:2];
                     prg_touch   = 1'b1;
                  end
                  RGN_CHR_LOW: begin
                     if (cfg.chr_is_ram) begin
                        prg_sel_in = {data[4], prg_sel_ff[3:0]} & cfg.prg_bank_mask;
                        prg_touch  = 1'b1;
                     end else begin
                        chr_sel_lo_in = data & cfg.chr_bank_mask;
                     end
                  end
                  RGN_CHR_HIGH: begin
                     if (chr_mode_ff) begin
                        if (cfg.chr_is_ram) begin
                           prg_sel_in = {data[4], prg_sel_ff[3:0]} & cfg.prg_bank_mask;
                           prg_touch  = 1'b1;
                        end else begin
                           chr_sel_hi_in = data & cfg.chr_bank_mask;
                        end
                     end
                  end
                  RGN_PRG: begin
                     prg_sel_in = {prg_sel_ff[4], data[3:0]} & cfg.prg_bank_mask;
                     prg_touch  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
      end
      prg_map_in = prg_touch ?
                   prg_remap(prg_win_in, prg_sel_in, cfg.prg_bank_count, prg_map_ff) :
                   prg_map_ff;
   end

   // pattern windows follow directly from the selects and mode
   assign chr_lo_bank = chr_mode_ff ? chr_sel_lo_ff : {chr_sel_lo_ff[4:1], 1'b0};
   assign chr_hi_bank = chr_mode_ff ? chr_sel_hi_ff : {chr_sel_lo_ff[4:1], 1'b1};
   assign last_bank   = cfg.prg_bank_count[4:0] - 5'd1;

   always_comb begin
      if (item.address < 16'hC000) begin
         prg_bank = prg_map_ff.low;
      end else if (prg_map_ff.is_last) begin
         prg_bank = last_bank;
      end else begin
         prg_bank = prg_map_ff.high;
      end
   end

   always_comb begin
      case (item.op)
         OP_PRG_READ: rom_offset = {prg_bank, item.address[13:0]};
         OP_CHR_READ: begin
            if (cfg.chr_is_ram) begin
               rom_offset = {3'd0, item.address};
            end else if (item.address < 16'h1000) begin
               rom_offset = {2'd0, chr_lo_bank, item.address[11:0]};
            end else begin
               rom_offset = {2'd0, chr_hi_bank, item.address[11:0]};
            end
         end
         default: rom_offset = 19'd0;
      endcase
   end

   assign mirroring = mirror_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff           <= SHIFT_MARK;
         last_cycle_ff      <= 32'd0;
         last_valid_ff      <= 1'b0;
         prg_win_ff         <= 2'd3;
         chr_mode_ff        <= 1'b0;
         prg_sel_ff         <= 5'd0;
         chr_sel_lo_ff      <= 5'd0;
         chr_sel_hi_ff      <= 5'd0;
         mirror_ff          <= 2'd0;
         prg_map_ff.low     <= 5'd0;
         prg_map_ff.high    <= 5'd0;
         prg_map_ff.is_last <= 1'b1;
      end else if (commit) begin
         shift_ff      <= shift_in;
         last_cycle_ff <= last_cycle_in;
         last_valid_ff <= last_valid_in;
         prg_win_ff    <= prg_win_in;
         chr_mode_ff   <= chr_mode_in;
         prg_sel_ff    <= prg_sel_in;
         chr_sel_lo_ff <= chr_sel_lo_in;
         chr_sel_hi_ff <= chr_sel_hi_in;
         mirror_ff     <= mirror_in;
         prg_map_ff    <= prg_map_in;
      end
   end

endmodule

/* tb/sv/serial_loaded_rom_bank_mapper_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_loaded_rom_bank_mapper_top_tb
// Self-checking bench for the bank mapper. A short table of directed requests
// covers reset state, field extremes, same-cycle and reset writes and an
// unmapped commit. Random serial loads, reads and noise then run under seven
// register settings. Both channels stall at random. Every response is checked
// against a cycle-free model of the mapper state kept in the bench.
// ----------------------------------------------------------------------------
module serial_loaded_rom_bank_mapper_top_tb;
   import slrbm_pkg::*;

   // op 3 has no function: it must answer offset 0 and leave state alone
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   // program window modes, control register bits 3..2
   localparam logic [1:0] PRG_WIN_32K_A     = 2'd0;
   localparam logic [1:0] PRG_WIN_32K_B     = 2'd1;
   localparam logic [1:0] PRG_WIN_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_WIN_FIX_LAST  = 2'd3;

   localparam int SIDE_REQ       = 0;
   localparam int SIDE_RSP       = 1;
   localparam int PHASE_REQUESTS = 90;
   localparam int SETTLE_CYCLES  = 4;    // lets the input and response registers drain, with margin

   typedef struct packed {
      logic [18:0] rom_offset;
      logic [1:0]  mirroring;
   } mapper_rsp_type;

   // one line of the directed table; known holds a hand-typed answer
   typedef struct {
      req_type        req;
      bit             typed;
      mapper_rsp_type known;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   slrbm_req_if req_ch ();
   slrbm_rsp_if rsp_ch ();

   serial_loaded_rom_bank_mapper_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // ------------------------------------------------------------------------
   // Mapper model: registers plus the serial load and bank state
   // ------------------------------------------------------------------------
   cfg_type     mapper_cfg;
   logic [5:0]  shift_reg;
   logic [31:0] prev_stamp;
   logic        prev_stamp_ok;
   logic [1:0]  prg_win_mode;
   logic        chr_split;        // 1: two independent 4 KiB pattern windows
   logic [4:0]  prg_sel;
   logic [4:0]  chr_sel_lo;
   logic [4:0]  chr_sel_hi;
   logic [1:0]  mirror;
   logic [4:0]  prg_bank_lo;
   logic [4:0]  prg_bank_hi;
   logic        prg_hi_last;      // high window follows the bank count live
   logic [4:0]  chr_bank_lo;
   logic [4:0]  chr_bank_hi;

   mapper_rsp_type expected_q[$];
   stim_row_type   directed_rows[$];
   int             fail_count;
   int             phase_count;
   logic [31:0]    bus_cycle;

   // idle pacing: each side runs stretches that are either calm (no gaps)
   // or gappy (a random idle gap before each item)
   int          stretch_left[2];
   bit          stretch_calm[2];

   function automatic void mapper_reset();
      mapper_cfg.prg_bank_count = 6'd2;
      mapper_cfg.prg_bank_mask  = 5'd1;
      mapper_cfg.chr_bank_mask  = 5'd1;
      mapper_cfg.chr_is_ram     = 1'b0;
      shift_reg     = SHIFT_MARK;
      prev_stamp    = '0;
      prev_stamp_ok = 1'b0;
      prg_win_mode  = PRG_WIN_FIX_LAST;
      chr_split     = 1'b0;
      prg_sel       = '0;
      chr_sel_lo    = '0;
      chr_sel_hi    = '0;
      mirror        = '0;
      prg_bank_lo   = '0;
      prg_bank_hi   = '0;
      prg_hi_last   = 1'b1;
      chr_bank_lo   = '0;
      chr_bank_hi   = 5'd1;
   endfunction

   function automatic void refresh_prg_banks();
      case (prg_win_mode)
         PRG_WIN_32K_A, PRG_WIN_32K_B: begin
            prg_bank_lo = prg_sel & 5'h1E;
            prg_bank_hi = prg_bank_lo + 5'd1;
            prg_hi_last = 1'b0;
         end
         PRG_WIN_FIX_FIRST: begin
            prg_bank_lo = prg_sel & 5'h10;
            prg_bank_hi = prg_sel;
            prg_hi_last = 1'b0;
         end
         default: begin
            prg_bank_lo = prg_sel;
            // large cartridge: high window picks bank 15 or 31 by select bit 4
            if (mapper_cfg.prg_bank_count > 6'd16) begin
               prg_bank_hi = prg_sel[4] ? 5'd31 : 5'd15;
               prg_hi_last = 1'b0;
            end else begin
               prg_hi_last = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic void refresh_chr_banks();
      if (chr_split) begin
         chr_bank_lo = chr_sel_lo;
         chr_bank_hi = chr_sel_hi;
      end else begin
         chr_bank_lo = chr_sel_lo & 5'h1E;
         chr_bank_hi = chr_bank_lo + 5'd1;
      end
   endfunction

   // pattern RAM: the pattern select regions write program select bit 4
   function automatic void load_prg_bit4(input logic [4:0] data);
      prg_sel = {data[4], prg_sel[3:0]} & mapper_cfg.prg_bank_mask;
      refresh_prg_banks();
   endfunction

   function automatic void serial_write(input logic [15:0] addr, input logic [7:0] value,
                                        input logic [31:0] stamp);
      logic       dup_cycle;
      logic [4:0] data;
      dup_cycle     = prev_stamp_ok && (stamp == prev_stamp);
      prev_stamp    = stamp;
      prev_stamp_ok = 1'b1;
      if (value[7]) begin
         // reset write: never dropped, even on a repeated cycle
         shift_reg    = SHIFT_MARK;
         prg_win_mode = PRG_WIN_FIX_LAST;
         refresh_prg_banks();
      end else if (!dup_cycle) begin
         shift_reg = {value[0], shift_reg[5:1]};
         if (shift_reg[0]) begin
            data = shift_reg[5:1];
            case (addr[15:13])
               RGN_CONTROL: begin
                  mirror       = data[1:0];
                  chr_split    = data[4];
                  prg_win_mode = data[3:2];
                  refresh_prg_banks();
                  refresh_chr_banks();
               end
               RGN_CHR_LOW: begin
                  if (mapper_cfg.chr_is_ram) begin
                     load_prg_bit4(data);
                  end else begin
                     chr_sel_lo = data & mapper_cfg.chr_bank_mask;
                     refresh_chr_banks();
                  end
               end
               RGN_CHR_HIGH: begin
                  // only meaningful with split pattern windows
                  if (chr_split && mapper_cfg.chr_is_ram) begin
                     load_prg_bit4(data);
                  end else if (chr_split) begin
                     chr_sel_hi = data & mapper_cfg.chr_bank_mask;
                     refresh_chr_banks();
                  end
               end
               RGN_PRG: begin
                  prg_sel = {prg_sel[4], data[3:0]} & mapper_cfg.prg_bank_mask;
                  refresh_prg_banks();
               end
               default: ;
            endcase
            shift_reg = SHIFT_MARK;
         end
      end
   endfunction

   function automatic mapper_rsp_type translate_request(input req_type r);
      mapper_rsp_type rsp;
      logic [4:0]     bank;
      logic [5:0]     last_bank;
      rsp.rom_offset = '0;
      last_bank      = mapper_cfg.prg_bank_count - 6'd1;
      case (r.op)
         OP_WRITE: serial_write(r.address, r.value, r.cycle_stamp);
         OP_PRG_READ: begin
            if (r.address < 16'hC000)
               bank = prg_bank_lo;
            else if (prg_hi_last)
               bank = last_bank[4:0];     // a count of 0 wraps to bank 31
            else
               bank = prg_bank_hi;
            rsp.rom_offset = {bank, r.address[13:0]};
         end
         OP_CHR_READ: begin
            if (mapper_cfg.chr_is_ram)
               rsp.rom_offset = {3'b000, r.address};
            else if (r.address < 16'h1000)
               rsp.rom_offset = {2'b00, chr_bank_lo, r.address[11:0]};
            else
               rsp.rom_offset = {2'b00, chr_bank_hi, r.address[11:0]};
         end
         default: ;
      endcase
      rsp.mirroring = mirror;
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pace_gap(input int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(8, 40);
         stretch_calm[side] = ($urandom_range(0, 3) == 0);
      end
      stretch_left[side]--;
      return stretch_calm[side] ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [15:0] address,
                                        input logic [7:0] value, input logic [31:0] stamp);
      req_type r;
      r.op          = op;
      r.address     = address;
      r.value       = value;
      r.cycle_stamp = stamp;
      return r;
   endfunction

   function automatic logic [31:0] next_stamp();
      bus_cycle = bus_cycle + $urandom_range(1, 3);
      return bus_cycle;
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic [15:0] address,
                                   input logic [7:0] value, input logic [31:0] stamp,
                                   input bit typed, input logic [18:0] offset,
                                   input logic [1:0] mirroring);
      stim_row_type row;
      row.req              = make_req(op, address, value, stamp);
      row.typed            = typed;
      row.known.rom_offset = offset;
      row.known.mirroring  = mirroring;
      directed_rows.push_back(row);
   endfunction

   // Valid stays high after acceptance; the next call either re-arms it with
   // new payload or drops it for a gap, so valid sees one update per step.
   task automatic issue_request(input req_type r, input bit typed,
                                input mapper_rsp_type known);
      int             gap;
      mapper_rsp_type predicted;
      gap = pace_gap(SIDE_REQ);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= r.op;
      req_ch.address     <= r.address;
      req_ch.value       <= r.value;
      req_ch.cycle_stamp <= r.cycle_stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = translate_request(r);
      expected_q.push_back(typed ? known : predicted);
      phase_count++;
   endtask

   // sender holds off until every response is back, then lets the pipe settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PRG_BANK_COUNT: mapper_cfg.prg_bank_count = data[5:0];
         REG_PRG_BANK_MASK:  mapper_cfg.prg_bank_mask  = data[4:0];
         REG_CHR_BANK_MASK:  mapper_cfg.chr_bank_mask  = data[4:0];
         REG_CHR_IS_RAM:     mapper_cfg.chr_is_ram     = data[0];
         default: ;
      endcase
   endtask

   task automatic random_read();
      logic [15:0] address;
      address = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         issue_request(make_req(OP_PRG_READ, address, 8'($urandom), $urandom), 1'b0, '0);
      end else begin
         // pattern reads mostly inside the 8 KiB PPU pattern space
         if ($urandom_range(0, 3) != 0)
            address[15:13] = 3'b000;
         issue_request(make_req(OP_CHR_READ, address, 8'($urandom), $urandom), 1'b0, '0);
      end
   endtask

   // Five-bit serial load with random content, sometimes preceded by a reset
   // write, sometimes broken by a repeated cycle stamp or a read in between.
   task automatic serial_sequence();
      logic [4:0]  data;
      logic [15:0] target;
      logic [15:0] address;
      logic [7:0]  value;
      logic [31:0] stamp;
      data   = 5'($urandom_range(0, 31));
      target = 16'($urandom);
      if ($urandom_range(0, 7) != 0)
         target[15] = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
         value    = 8'($urandom);
         value[7] = 1'b1;
         issue_request(make_req(OP_WRITE, 16'($urandom), value, next_stamp()), 1'b0, '0);
      end
      for (int i = 0; i < 5; i++) begin
         if ($urandom_range(0, 7) == 0)
            random_read();
         value    = 8'($urandom_range(0, 127));
         value[0] = data[i];
         stamp    = ($urandom_range(0, 11) == 0) ? bus_cycle : next_stamp();
         address  = (i == 4) ? target : 16'($urandom);
         issue_request(make_req(OP_WRITE, address, value, stamp), 1'b0, '0);
      end
   endtask

   task automatic run_setting(input logic [5:0] count, input logic [4:0] prg_mask,
                              input logic [4:0] chr_mask, input logic chr_ram);
      int pick;
      wait_idle();
      csr_write(REG_PRG_BANK_COUNT, {26'd0, count});
      csr_write(REG_PRG_BANK_MASK,  {27'd0, prg_mask});
      csr_write(REG_CHR_BANK_MASK,  {27'd0, chr_mask});
      csr_write(REG_CHR_IS_RAM,     {31'd0, chr_ram});
      phase_count = 0;
      while (phase_count < PHASE_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            serial_sequence();
         else if (pick < 80)
            random_read();
         else if (pick < 94)
            issue_request(make_req(OP_WRITE, 16'($urandom), 8'($urandom),
                          ($urandom_range(0, 3) == 0) ? bus_cycle : next_stamp()), 1'b0, '0);
         else
            issue_request(make_req(OP_UNDEFINED, 16'($urandom), 8'($urandom), $urandom),
                          1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 2 ms leaves a wide margin over the slowest run
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random backpressure and in-order checking
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pace_gap(SIDE_RSP);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      mapper_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("response with no request pending: rom_offset 0x%05h mirroring %0d",
                   rsp_ch.rom_offset, rsp_ch.mirroring);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.rom_offset !== want.rom_offset) begin
               $error("rom_offset: expected 0x%05h, got 0x%05h",
                      want.rom_offset, rsp_ch.rom_offset);
               fail_count++;
            end
            if (rsp_ch.mirroring !== want.mirroring) begin
               $error("mirroring: expected %0d, got %0d", want.mirroring, rsp_ch.mirroring);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      fail_count         = 0;
      phase_count        = 0;
      stretch_left       = '{0, 0};
      stretch_calm       = '{0, 0};
      mapper_reset();
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_WRITE;
      req_ch.address     <= '0;
      req_ch.value       <= '0;
      req_ch.cycle_stamp <= '0;

      // reset defaults: 2 program banks, masks 1, pattern ROM
      add_row(OP_PRG_READ,  16'h8000, 8'h00, 32'd0, 1'b1, 19'h00000, 2'd0);
      add_row(OP_PRG_READ,  16'hFFFF, 8'h00, 32'd0, 1'b1, 19'h07FFF, 2'd0); // last bank
      add_row(OP_CHR_READ,  16'h0000, 8'h00, 32'd0, 1'b1, 19'h00000, 2'd0);
      add_row(OP_CHR_READ,  16'h1FFF, 8'h00, 32'd0, 1'b1, 19'h01FFF, 2'd0);
      add_row(OP_UNDEFINED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 19'h00000, 2'd0);
      // first write at stamp 0 counts; a second one at stamp 0 is dropped
      add_row(OP_WRITE,     16'h8000, 8'h00, 32'd0, 1'b1, 19'h00000, 2'd0);
      add_row(OP_WRITE,     16'h8000, 8'h01, 32'd0, 1'b1, 19'h00000, 2'd0);
      add_row(OP_WRITE,     16'h9FFF, 8'hFE, 32'd1, 1'b1, 19'h00000, 2'd0); // reset write
      // control load 0x1A: vertical, fixed-first program, split pattern
      add_row(OP_WRITE,     16'h9ABC, 8'h7E, 32'd2, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'h9ABC, 8'h01, 32'd3, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'h9ABC, 8'h40, 32'd4, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'h9ABC, 8'h7F, 32'd5, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'h9ABC, 8'h03, 32'd6, 1'b1, 19'h00000, 2'd2);
      // repeated stamp dropped, but a reset write on it still lands
      add_row(OP_WRITE,     16'hE000, 8'h01, 32'd6, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'hA000, 8'h80, 32'd6, 1'b0, '0, '0);
      add_row(OP_PRG_READ,  16'hBFFF, 8'h00, 32'd0, 1'b0, '0, '0);
      add_row(OP_PRG_READ,  16'hC000, 8'h00, 32'd0, 1'b0, '0, '0);
      // fifth write below 0x8000 only clears the shift register
      add_row(OP_WRITE,     16'h7FFF, 8'h01, 32'd7,  1'b0, '0, '0);
      add_row(OP_WRITE,     16'h7FFF, 8'h00, 32'd8,  1'b0, '0, '0);
      add_row(OP_WRITE,     16'h7FFF, 8'h01, 32'd9,  1'b0, '0, '0);
      add_row(OP_WRITE,     16'h7FFF, 8'h00, 32'd10, 1'b0, '0, '0);
      add_row(OP_WRITE,     16'h7FFF, 8'h01, 32'd11, 1'b0, '0, '0);
      add_row(OP_CHR_READ,  16'h0FFF, 8'h00, 32'd0, 1'b0, '0, '0);
      add_row(OP_CHR_READ,  16'h1000, 8'h00, 32'd0, 1'b0, '0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].known);

      // random part: extremes of every register among the settings
      bus_cycle = $urandom;
      run_setting(6'd32, 5'd31, 5'd31, 1'b0);
      run_setting(6'd1,  5'd0,  5'd0,  1'b1);
      run_setting(6'd0,  5'd31, 5'd31, 1'b0);   // count 0: last bank wraps to 31
      run_setting(6'd63, 5'd31, 5'd31, 1'b1);
      run_setting(6'd17, 5'd15, 5'd7,  1'b0);
      run_setting(6'd16, 5'd31, 5'd3,  1'b1);
      run_setting(6'd8,  5'd7,  5'd31, 1'b0);

      wait_idle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
